>>> rtl/pre_trade_risk_gate_macros.svh
// ============================================================================
// pre_trade_risk_gate_macros.svh
// Assertion macros used by the top-level risk gate module.
// ============================================================================
`ifndef PRE_TRADE_RISK_GATE_MACROS_SVH
`define PRE_TRADE_RISK_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTRG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pre_trade_risk_gate: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PTRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pre_trade_risk_gate: next-cycle check failed");

`endif

>>> rtl/ptrg_pkg.sv
// ============================================================================
// ptrg_pkg
// Types and constants shared by the pre-trade risk gate modules.
// ============================================================================
package ptrg_pkg;

   // Operation selector carried with each request.
   typedef enum logic [1:0] {
      OP_CHECK      = 2'd0,
      OP_FILL       = 2'd1,
      OP_SET_LIMITS = 2'd2,
      OP_QUERY      = 2'd3
   } ptrg_opcode_type;

   // Check outcome.
   typedef enum logic [1:0] {
      VERDICT_ACCEPT   = 2'd0,
      VERDICT_SIZE     = 2'd1,
      VERDICT_POSITION = 2'd2,
      VERDICT_RATE     = 2'd3
   } ptrg_verdict_type;

   localparam int unsigned WINDOW_W  = 40;
   localparam int unsigned REQ_BYTES = 28;
   localparam int unsigned RSP_BYTES = 21;

   // One table entry, as stored in the entry memory.
   typedef struct packed {
      logic [31:0]        size_limit;
      logic [46:0]        position_limit;
      logic [31:0]        rate_limit;
      logic signed [47:0] position;
      logic [63:0]        window_base;
      logic [31:0]        window_count;
   } ptrg_entry_type;

   // Entry contents for a newly created or absent entry.
   localparam ptrg_entry_type ENTRY_DEFAULT = '{
      size_limit:     32'hFFFF_FFFF,
      position_limit: 47'h7FFF_FFFF_FFFF,
      rate_limit:     32'hFFFF_FFFF,
      position:       48'sd0,
      window_base:    64'd0,
      window_count:   32'd0
   };

   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

   // Unpacked request fields.
   typedef struct packed {
      ptrg_opcode_type opcode;
      logic [7:0]      symbol_index;
      logic [5:0]      participant_index;
      logic            side;
      logic [31:0]     quantity;
      logic [63:0]     timestamp;
      logic [31:0]     new_order_size_limit;
      logic [46:0]     new_position_limit;
      logic [31:0]     new_rate_limit;
   } ptrg_request_type;

   // Table write command (address travels beside it).
   typedef struct packed {
      logic           en;
      logic           present;
      ptrg_entry_type entry;
   } ptrg_write_type;

   // Result fields of one request.
   typedef struct packed {
      ptrg_verdict_type   verdict;
      logic signed [47:0] entry_position;
      logic [31:0]        cur_order_size_limit;
      logic [46:0]        cur_position_limit;
      logic [31:0]        cur_rate_limit;
   } ptrg_response_type;

endpackage

>>> rtl/ptrg_table.sv
// ============================================================================
// ptrg_table
// Entry memory and present-flag memory with registered reads and a clearing
// pass over the present flags after reset.
// ============================================================================
module ptrg_table #(
   parameter int unsigned DEPTH = 16384
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic                           rd_present,
   output ptrg_pkg::ptrg_entry_type       rd_entry,
   input  ptrg_pkg::ptrg_write_type       wr_cmd,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   output logic                           clear_busy
);

   localparam int unsigned KEY_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [KEY_W-1:0] LAST_ADDR = KEY_W'(DEPTH - 1);

   ptrg_pkg::ptrg_entry_type entry_mem [DEPTH];
   logic                     present_mem [DEPTH];

   logic                     rd_present_ff;
   ptrg_pkg::ptrg_entry_type rd_entry_ff;
   logic [KEY_W-1:0]         clr_addr_ff;
   logic [KEY_W-1:0]         clr_addr_in;
   logic                     clr_busy_ff;
   logic                     clr_busy_in;

   // Clearing sweep: one present flag per cycle after reset.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + KEY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Present-flag memory: the sweep owns the write port while it runs.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         present_mem[clr_addr_ff] <= 1'b0;
      end else if (wr_cmd.en) begin
         present_mem[wr_addr] <= wr_cmd.present;
      end
      if (rd_en) begin
         rd_present_ff <= present_mem[rd_addr];
      end
   end

   // Entry memory.
   always_ff @(posedge clock) begin
      if (wr_cmd.en) begin
         entry_mem[wr_addr] <= wr_cmd.entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_present = rd_present_ff;
   assign rd_entry   = rd_entry_ff;
   assign clear_busy = clr_busy_ff;

endmodule

>>> rtl/ptrg_eval.sv
// ============================================================================
// ptrg_eval
// Risk evaluation datapath: a registered stage of sums and differences,
// followed by the limit comparisons that build the updated entry.
// ============================================================================
module ptrg_eval (
   input  logic                         clock,
   input  logic                         stage_en,
   input  ptrg_pkg::ptrg_request_type   req,
   input  logic                         key_ok,
   input  logic                         rd_present,
   input  ptrg_pkg::ptrg_entry_type     rd_entry,
   input  logic [ptrg_pkg::WINDOW_W-1:0] rate_window,
   output ptrg_pkg::ptrg_write_type     wr_cmd,
   output ptrg_pkg::ptrg_response_type  rsp
);

   typedef struct packed {
      ptrg_pkg::ptrg_request_type req;
      logic                       key_ok;
      logic                       present;
      ptrg_pkg::ptrg_entry_type   base;
      logic signed [48:0]         next_pos;
      logic [63:0]                elapsed;
      logic [31:0]                count_inc;
   } stage_type;

   stage_type                stage_ff;
   stage_type                stage_in;
   logic signed [48:0]       pos_wide;
   logic signed [48:0]       qty_wide;

   // First stage: choose the base entry and form the sums.
   always_comb begin
      stage_in.req     = req;
      stage_in.key_ok  = key_ok;
      stage_in.present = key_ok && rd_present;
      stage_in.base    = stage_in.present ? rd_entry : ptrg_pkg::ENTRY_DEFAULT;
      pos_wide = {stage_in.base.position[47], stage_in.base.position};
      qty_wide = $signed({17'b0, req.quantity});
      stage_in.next_pos  = req.side ? (pos_wide - qty_wide) : (pos_wide + qty_wide);
      stage_in.elapsed   = req.timestamp - stage_in.base.window_base;
      stage_in.count_inc = stage_in.base.window_count + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         stage_ff <= stage_in;
      end
   end

   // Second stage: limit tests and the updated entry.
   ptrg_pkg::ptrg_entry_type   upd;
   ptrg_pkg::ptrg_verdict_type verdict;
   logic                       wr_en;
   logic                       over_size;
   logic                       over_pos;
   logic                       restart;
   logic                       rate_hit;
   logic signed [48:0]         lim_wide;
   logic [31:0]                count_now;

   always_comb begin
      lim_wide  = $signed({2'b0, stage_ff.base.position_limit});
      over_size = stage_ff.req.quantity > stage_ff.base.size_limit;
      over_pos  = (stage_ff.next_pos > lim_wide) || (stage_ff.next_pos < -lim_wide);
      restart   = stage_ff.elapsed >= {24'b0, rate_window};
      count_now = restart ? 32'd0 : stage_ff.base.window_count;
      rate_hit  = count_now >= stage_ff.base.rate_limit;

      upd     = stage_ff.base;
      verdict = ptrg_pkg::VERDICT_ACCEPT;
      wr_en   = 1'b0;

      if (stage_ff.key_ok) begin
         unique case (stage_ff.req.opcode)
            ptrg_pkg::OP_CHECK: begin
               if (stage_ff.present) begin
                  wr_en = 1'b1;
                  if (over_size) begin
                     verdict = ptrg_pkg::VERDICT_SIZE;
                  end else if (over_pos) begin
                     verdict = ptrg_pkg::VERDICT_POSITION;
                  end else begin
                     // A restarted window is kept even when the rate test rejects.
                     if (restart) begin
                        upd.window_base  = stage_ff.req.timestamp;
                        upd.window_count = 32'd0;
                     end
                     if (rate_hit) begin
                        verdict = ptrg_pkg::VERDICT_RATE;
                     end else begin
                        upd.window_count = restart ? 32'd1 : stage_ff.count_inc;
                     end
                  end
               end
            end
            ptrg_pkg::OP_FILL: begin
               wr_en = 1'b1;
               // Saturate when the two top bits of the sum disagree.
               if (stage_ff.next_pos[48] != stage_ff.next_pos[47]) begin
                  upd.position = stage_ff.next_pos[48] ? ptrg_pkg::POS_MIN
                                                       : ptrg_pkg::POS_MAX;
               end else begin
                  upd.position = stage_ff.next_pos[47:0];
               end
            end
            ptrg_pkg::OP_SET_LIMITS: begin
               wr_en = 1'b1;
               upd.size_limit     = stage_ff.req.new_order_size_limit;
               upd.position_limit = stage_ff.req.new_position_limit;
               upd.rate_limit     = stage_ff.req.new_rate_limit;
            end
            ptrg_pkg::OP_QUERY: begin
               wr_en = 1'b0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   assign wr_cmd.en      = wr_en;
   assign wr_cmd.present = 1'b1;
   assign wr_cmd.entry   = upd;

   // An absent or out-of-range entry starts from the defaults.
   assign rsp.verdict              = verdict;
   assign rsp.entry_position       = upd.position;
   assign rsp.cur_order_size_limit = upd.size_limit;
   assign rsp.cur_position_limit   = upd.position_limit;
   assign rsp.cur_rate_limit       = upd.rate_limit;

endmodule

>>> rtl/pre_trade_risk_gate.sv
// ============================================================================
// pre_trade_risk_gate
// Pre-trade risk check over a symbol by participant table of limits,
// positions and order-rate windows.
// ============================================================================
// Usage:
//   Requests enter on the req_ stream (opcode in req_tuser, all other fields
//   in req_tdata); one result per request leaves on the rsp_ stream.
//   The rate window length is written through csr_valid/csr_wdata, which is
//   always ready and should be written only while the gate is idle.
//   Each request does one read-modify-write of its table entry: a memory
//   read, a sum/difference step and a compare/write-back step.
//   A new request is taken in the write-back cycle of the one before once
//   the output register is free, so requests do not overlap in the datapath.
//   Since each write-back lands before the next read, requests to the same
//   entry see each other's updates.
//   After reset the present flags of all NUM_SYMBOLS * NUM_PARTICIPANTS
//   entries (16384 by default) are cleared by a sweep, during which
//   req_tready stays low; csr writes are taken throughout.
//   The result sits in an output register. While rsp_tready is low the gate
//   still takes one request and holds it in write-back until the register
//   frees up.
// ============================================================================
`include "pre_trade_risk_gate_macros.svh"

module pre_trade_risk_gate #(
   parameter int unsigned NUM_SYMBOLS      = 256,
   parameter int unsigned NUM_PARTICIPANTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   // Request stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: symbol_index[8], participant_index[6], side[1],
   // quantity[32], timestamp[64], new_order_size_limit[32],
   // new_position_limit[47], new_rate_limit[32], zero fill[2]
   input  logic [8*ptrg_pkg::REQ_BYTES-1:0] req_tdata,
   // tuser: opcode[2]
   input  logic [1:0]   req_tuser,
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: verdict[2], entry_position[48], cur_order_size_limit[32],
   // cur_position_limit[47], cur_rate_limit[32], zero fill[7]
   output logic [8*ptrg_pkg::RSP_BYTES-1:0] rsp_tdata,
   // Rate window register.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [ptrg_pkg::WINDOW_W-1:0] csr_wdata
);

   localparam int unsigned DEPTH = NUM_SYMBOLS * NUM_PARTICIPANTS;
   localparam int unsigned KEY_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ptrg_pkg::WINDOW_W-1:0] WINDOW_RESET = 40'd1000000000;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOK   = 4'b0010,
      ST_CALC   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   ptrg_pkg::ptrg_request_type   req_ff;
   ptrg_pkg::ptrg_request_type   req_in;
   logic [KEY_W-1:0]             key_ff;
   logic [KEY_W-1:0]             key_in;
   logic                         key_ok_ff;
   logic                         key_ok_in;
   logic [ptrg_pkg::WINDOW_W-1:0] window_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [8*ptrg_pkg::RSP_BYTES-1:0] rsp_data_ff;
   logic [8*ptrg_pkg::RSP_BYTES-1:0] rsp_data_in;

   logic                         req_fire;
   logic                         out_free;
   logic                         commit_go;
   logic                         clear_busy;
   logic                         rd_present;
   ptrg_pkg::ptrg_entry_type     rd_entry;
   ptrg_pkg::ptrg_write_type     eval_wr;
   ptrg_pkg::ptrg_write_type     tbl_wr;
   ptrg_pkg::ptrg_response_type  eval_rsp;
   logic [31:0]                  key_full;

   // Unpack the request.
   always_comb begin
      req_in.opcode               = ptrg_pkg::ptrg_opcode_type'(req_tuser);
      req_in.symbol_index         = req_tdata[7:0];
      req_in.participant_index    = req_tdata[13:8];
      req_in.side                 = req_tdata[14];
      req_in.quantity             = req_tdata[46:15];
      req_in.timestamp            = req_tdata[110:47];
      req_in.new_order_size_limit = req_tdata[142:111];
      req_in.new_position_limit   = req_tdata[189:143];
      req_in.new_rate_limit       = req_tdata[221:190];
   end

   // Handshake control.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit_go  = (state_ff == ST_COMMIT) && out_free;
   assign req_tready = !clear_busy && ((state_ff == ST_IDLE) || commit_go);
   assign req_fire   = req_tvalid && req_tready;

   // Key of the held request.
   always_comb begin
      key_ok_in = ({24'b0, req_ff.symbol_index} < 32'(NUM_SYMBOLS)) &&
                  ({26'b0, req_ff.participant_index} < 32'(NUM_PARTICIPANTS));
      key_full  = {24'b0, req_ff.symbol_index} * 32'(NUM_PARTICIPANTS) +
                  {26'b0, req_ff.participant_index};
      key_in    = key_ok_in ? key_full[KEY_W-1:0] : '0;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = req_fire ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request and key registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_in;
      end
      if (state_ff == ST_LOOK) begin
         key_ff    <= key_in;
         key_ok_ff <= key_ok_in;
      end
   end

   // Rate window register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid) begin
         window_ff <= csr_wdata;
      end
   end

   ptrg_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (state_ff == ST_LOOK),
      .rd_addr    (key_in),
      .rd_present (rd_present),
      .rd_entry   (rd_entry),
      .wr_cmd     (tbl_wr),
      .wr_addr    (key_ff),
      .clear_busy (clear_busy)
   );

   ptrg_eval u_eval (
      .clock       (clock),
      .stage_en    (state_ff == ST_CALC),
      .req         (req_ff),
      .key_ok      (key_ok_ff),
      .rd_present  (rd_present),
      .rd_entry    (rd_entry),
      .rate_window (window_ff),
      .wr_cmd      (eval_wr),
      .rsp         (eval_rsp)
   );

   // Write back only in the cycle the result is loaded.
   always_comb begin
      tbl_wr    = eval_wr;
      tbl_wr.en = eval_wr.en && commit_go;
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, eval_rsp.cur_rate_limit, eval_rsp.cur_position_limit,
                         eval_rsp.cur_order_size_limit, eval_rsp.entry_position,
                         eval_rsp.verdict};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks.
   `PTRG_ASSERT_NOW(a_write_in_commit, clock, reset, tbl_wr.en, commit_go)
   `PTRG_ASSERT_NEXT(a_commit_shows_result, clock, reset, commit_go, rsp_tvalid)
   `PTRG_ASSERT_NEXT(a_accept_starts_read, clock, reset, req_fire, state_ff == ST_LOOK)
   `PTRG_ASSERT_NOW(a_no_accept_in_sweep, clock, reset, clear_busy, !req_fire)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the pre-trade risk gate. A behavioral copy of the
// risk table predicts every result, which is compared field by field with
// the rsp_ stream. Directed tests cover absent entries, every rejection
// path, window restarts and large fills; random traffic runs under
// several window lengths with random idling on both streams.
// ============================================================================
module testbench;

   localparam int unsigned SYMBOLS         = 256;
   localparam int unsigned PARTICIPANTS    = 64;
   localparam int unsigned ENTRIES         = SYMBOLS * PARTICIPANTS;
   // Covers the clearing sweep after reset with a wide margin.
   localparam int unsigned WATCHDOG_CYCLES = 50000;
   localparam bit          BUY             = 1'b0;
   localparam bit          SELL            = 1'b1;
   localparam longint      POS_HI          = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint      POS_LO          = -POS_HI - 1;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [8*ptrg_pkg::REQ_BYTES-1:0]    req_tdata;
   logic [1:0]                          req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [8*ptrg_pkg::RSP_BYTES-1:0]    rsp_tdata;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [ptrg_pkg::WINDOW_W-1:0]       csr_wdata;

   // Shadow copy of the risk table and the window register.
   bit                         live [ENTRIES];
   bit [31:0]                  size_cap [ENTRIES];
   bit [46:0]                  pos_cap [ENTRIES];
   bit [31:0]                  rate_cap [ENTRIES];
   longint                     net_pos [ENTRIES];
   bit [63:0]                  window_open [ENTRIES];
   bit [31:0]                  window_orders [ENTRIES];
   bit [39:0]                  window_len = 40'd1000000000;

   ptrg_pkg::ptrg_response_type pending_answers [$];
   int unsigned                error_count = 0;
   int unsigned                stall_cycles = 0;
   bit                         steady = 1'b0;

   pre_trade_risk_gate #(
      .NUM_SYMBOLS      (SYMBOLS),
      .NUM_PARTICIPANTS (PARTICIPANTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the answer it must give.
   function automatic ptrg_pkg::ptrg_response_type risk_step(
      ptrg_pkg::ptrg_request_type r);
      int unsigned                 key;
      longint                      delta;
      longint                      next_pos;
      longint                      cap;
      ptrg_pkg::ptrg_response_type rsp;
      key   = r.symbol_index * PARTICIPANTS + r.participant_index;
      delta = {32'd0, r.quantity};
      if (r.side == SELL) begin
         delta = -delta;
      end
      rsp.verdict = ptrg_pkg::VERDICT_ACCEPT;

      // Fills and limit updates bring an absent entry to life with no limits.
      if ((r.opcode == ptrg_pkg::OP_FILL || r.opcode == ptrg_pkg::OP_SET_LIMITS) &&
          !live[key]) begin
         live[key]          = 1'b1;
         size_cap[key]      = '1;
         pos_cap[key]       = '1;
         rate_cap[key]      = '1;
         net_pos[key]       = 0;
         window_open[key]   = '0;
         window_orders[key] = '0;
      end

      case (r.opcode)
         ptrg_pkg::OP_CHECK: begin
            if (live[key]) begin
               next_pos = net_pos[key] + delta;
               cap      = {17'd0, pos_cap[key]};
               if (r.quantity > size_cap[key]) begin
                  rsp.verdict = ptrg_pkg::VERDICT_SIZE;
               end else if (next_pos > cap || next_pos < -cap) begin
                  rsp.verdict = ptrg_pkg::VERDICT_POSITION;
               end else begin
                  // Elapsed time is a wrapping 64-bit difference.
                  if (r.timestamp - window_open[key] >= {24'd0, window_len}) begin
                     window_open[key]   = r.timestamp;
                     window_orders[key] = '0;
                  end
                  if (window_orders[key] >= rate_cap[key]) begin
                     rsp.verdict = ptrg_pkg::VERDICT_RATE;
                  end else begin
                     window_orders[key] = window_orders[key] + 32'd1;
                  end
               end
            end
         end
         ptrg_pkg::OP_FILL: begin
            next_pos = net_pos[key] + delta;
            if (next_pos > POS_HI) begin
               next_pos = POS_HI;
            end
            if (next_pos < POS_LO) begin
               next_pos = POS_LO;
            end
            net_pos[key] = next_pos;
         end
         ptrg_pkg::OP_SET_LIMITS: begin
            size_cap[key] = r.new_order_size_limit;
            pos_cap[key]  = r.new_position_limit;
            rate_cap[key] = r.new_rate_limit;
         end
         default: begin
         end
      endcase

      if (live[key]) begin
         rsp.entry_position       = net_pos[key][47:0];
         rsp.cur_order_size_limit = size_cap[key];
         rsp.cur_position_limit   = pos_cap[key];
         rsp.cur_rate_limit       = rate_cap[key];
      end else begin
         rsp.entry_position       = '0;
         rsp.cur_order_size_limit = '1;
         rsp.cur_position_limit   = '1;
         rsp.cur_rate_limit       = '1;
      end
      return rsp;
   endfunction

   function automatic ptrg_pkg::ptrg_request_type make_request(
      ptrg_pkg::ptrg_opcode_type op, bit [7:0] sym, bit [5:0] part, bit side,
      bit [31:0] qty, bit [63:0] ts, bit [31:0] size_lim = '0, bit [46:0] pos_lim = '0,
      bit [31:0] rate_lim = '0);
      ptrg_pkg::ptrg_request_type r;
      r.opcode               = op;
      r.symbol_index         = sym;
      r.participant_index    = part;
      r.side                 = side;
      r.quantity             = qty;
      r.timestamp            = ts;
      r.new_order_size_limit = size_lim;
      r.new_position_limit   = pos_lim;
      r.new_rate_limit       = rate_lim;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   // Sends one request after a random gap and records its predicted answer.
   task automatic send_request(input ptrg_pkg::ptrg_request_type r);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.opcode;
      req_tdata  <= {2'b00, r.new_rate_limit, r.new_position_limit, r.new_order_size_limit,
                     r.timestamp, r.quantity, r.side, r.participant_index, r.symbol_index};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(risk_step(r));
   endtask

   // Holds off new requests until every outstanding result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // Writes the window length while the gate is idle.
   task automatic set_window(input bit [39:0] len);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      window_len = len;
   endtask

   // Absent entries answer with defaults, and checks on them always pass.
   task automatic test_absent_entries();
      send_request(make_request(ptrg_pkg::OP_QUERY, 8'd0, 6'd0, BUY, 32'd0, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd255, 6'd63, SELL, '1, '1));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd0, 6'd63, BUY, 32'd0, 64'd0));
      send_request(make_request(ptrg_pkg::OP_QUERY, 8'd255, 6'd0, SELL, '1, '1, '1, '1,
                                '1));
   endtask

   // Walks one entry through every rejection path and both window restarts.
   task automatic test_order_checks();
      set_window(40'd1000);
      send_request(make_request(ptrg_pkg::OP_SET_LIMITS, 8'd3, 6'd7, BUY, 32'd0, 64'd0,
                                32'd50, 47'd100, 32'd2));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd51, 64'd5000));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd50, 64'd5000));
      send_request(make_request(ptrg_pkg::OP_FILL, 8'd3, 6'd7, BUY, 32'd80, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd21, 64'd5010));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, SELL, 32'd100, 64'd5010));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, SELL, 32'd0, 64'd5999));
      // Exactly one window later, then a timestamp that went backwards.
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd0, 64'd6000));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd0, 64'd100));
      send_request(make_request(ptrg_pkg::OP_FILL, 8'd3, 6'd7, SELL, 32'd300, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd0, 64'd150));
      // Zero limits keep the position, and a zero-quantity order is blocked on rate.
      send_request(make_request(ptrg_pkg::OP_SET_LIMITS, 8'd3, 6'd7, BUY, 32'd0, 64'd0,
                                32'd0, 47'd0, 32'd0));
      send_request(make_request(ptrg_pkg::OP_FILL, 8'd3, 6'd7, BUY, 32'd220, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd0, 64'd200));
      send_request(make_request(ptrg_pkg::OP_QUERY, 8'd3, 6'd7, BUY, 32'd0, 64'd0));
      send_request(make_request(ptrg_pkg::OP_SET_LIMITS, 8'd200, 6'd40, SELL, '1, '1,
                                '1, '1, '1));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd200, 6'd40, SELL, '1, '1));
      send_request(make_request(ptrg_pkg::OP_FILL, 8'd1, 6'd1, SELL, 32'd9, 64'd0));
   endtask

   // Zero, one and the largest window length.
   task automatic test_window_extremes();
      set_window(40'd0);
      send_request(make_request(ptrg_pkg::OP_SET_LIMITS, 8'd3, 6'd7, BUY, 32'd0, 64'd0,
                                '1, '1, 32'd1));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd1, 64'd7));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd1, 64'd7));
      set_window(40'hFF_FFFF_FFFF);
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, SELL, 32'd1, 64'd7));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, SELL, 32'd1,
                                64'h100_0000_0006));
      set_window(40'd1);
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd1, 64'd50));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd1, 64'd50));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd3, 6'd7, BUY, 32'd1, 64'd51));
   endtask

   // Pushes one entry far up and another far down with the largest fills,
   // back to back, then probes both with checks.
   task automatic test_large_fills();
      int unsigned i;
      steady = 1'b1;
      for (i = 0; i < 8; i++) begin
         send_request(make_request(ptrg_pkg::OP_FILL, 8'd17, 6'd5, BUY, '1, 64'd0));
         send_request(make_request(ptrg_pkg::OP_FILL, 8'd18, 6'd5, SELL, '1, 64'd0));
      end
      steady = 1'b0;
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd17, 6'd5, BUY, 32'd1, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd17, 6'd5, SELL, '1, 64'd0));
      send_request(make_request(ptrg_pkg::OP_CHECK, 8'd18, 6'd5, SELL, 32'd1, 64'd0));
      send_request(make_request(ptrg_pkg::OP_QUERY, 8'd18, 6'd5, BUY, 32'd0, 64'd0));
   endtask

   // Random traffic mostly on a few live entries, under several window lengths.
   task automatic test_random_traffic();
      bit [39:0]                  windows [6];
      bit [7:0]                   pool_sym [4];
      bit [5:0]                   pool_part [4];
      ptrg_pkg::ptrg_request_type r;
      bit [63:0]                  now_ns;
      bit [63:0]                  wide;
      int unsigned                phase;
      int unsigned                n;
      int unsigned                slot;
      int unsigned                pick;
      windows      = '{40'd1000000000, 40'd1, 40'd64, 40'd4096, 40'hFF_FFFF_FFFF,
                       40'd100000};
      pool_sym[0]  = 8'd255;
      pool_part[0] = 6'd63;
      pool_sym[1]  = 8'd0;
      pool_part[1] = 6'd0;
      for (slot = 2; slot < 4; slot++) begin
         pool_sym[slot]  = 8'($urandom_range(0, 255));
         pool_part[slot] = 6'($urandom_range(0, 63));
      end
      now_ns = {$urandom, $urandom};

      for (phase = 0; phase < 6; phase++) begin
         set_window(windows[phase]);
         for (n = 0; n < 200; n++) begin
            // Every third stretch of 40 requests runs with no idling.
            steady = ((n / 40) % 3) == 2;
            if (n % 70 == 69) begin
               wait_drained();
            end

            // Key: mostly from the pool, sometimes anywhere in the table.
            slot                = $urandom_range(0, 3);
            r.symbol_index      = pool_sym[slot];
            r.participant_index = pool_part[slot];
            if ($urandom_range(0, 9) == 0) begin
               r.symbol_index      = 8'($urandom_range(0, 255));
               r.participant_index = 6'($urandom_range(0, 63));
            end

            pick = $urandom_range(0, 19);
            if (pick < 10) begin
               r.opcode = ptrg_pkg::OP_CHECK;
            end else if (pick < 14) begin
               r.opcode = ptrg_pkg::OP_FILL;
            end else if (pick < 17) begin
               r.opcode = ptrg_pkg::OP_SET_LIMITS;
            end else begin
               r.opcode = ptrg_pkg::OP_QUERY;
            end
            r.side = 1'($urandom_range(0, 1));

            pick = $urandom_range(0, 19);
            if (pick < 16) begin
               r.quantity = $urandom_range(0, 130);
            end else if (pick < 18) begin
               r.quantity = $urandom;
            end else begin
               r.quantity = '1;
            end

            // Time mostly creeps forward, with jumps around the window edge.
            pick = $urandom_range(0, 49);
            wide = {$urandom, $urandom};
            if (pick < 30) begin
               now_ns = now_ns + wide % (({24'd0, window_len} >> 6) + 1);
            end else if (pick == 40) begin
               now_ns = now_ns + {24'd0, window_len} - 1;
            end else if (pick == 41) begin
               now_ns = now_ns + {24'd0, window_len};
            end else if (pick == 42) begin
               now_ns = now_ns + {24'd0, window_len} + 1;
            end else if (pick == 43) begin
               now_ns = wide;
            end else if (pick == 44) begin
               now_ns = now_ns - 64'($urandom_range(1, 1000));
            end
            r.timestamp = now_ns;

            pick = $urandom_range(0, 9);
            wide = {$urandom, $urandom};
            if (pick < 7) begin
               r.new_order_size_limit = $urandom_range(0, 120);
               r.new_position_limit   = 47'($urandom_range(0, 600));
               r.new_rate_limit       = $urandom_range(0, 6);
            end else if (pick == 7) begin
               r.new_order_size_limit = '0;
               r.new_position_limit   = '0;
               r.new_rate_limit       = '0;
            end else if (pick == 8) begin
               r.new_order_size_limit = $urandom;
               r.new_position_limit   = wide[46:0];
               r.new_rate_limit       = $urandom;
            end else begin
               r.new_order_size_limit = '1;
               r.new_position_limit   = '1;
               r.new_rate_limit       = '1;
            end
            send_request(r);
         end
      end
      steady = 1'b0;
   endtask

   // Result side: a random stall before each result is taken.
   always begin
      int unsigned stall;
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!rsp_tvalid);
   end

   // Compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      ptrg_pkg::ptrg_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unrequested result", rsp_tdata[63:0], '0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[1:0] !== want.verdict) begin
               report_mismatch("verdict", 64'(rsp_tdata[1:0]), 64'(want.verdict));
            end
            if (rsp_tdata[49:2] !== want.entry_position) begin
               report_mismatch("entry_position", 64'(rsp_tdata[49:2]),
                               64'($unsigned(want.entry_position)));
            end
            if (rsp_tdata[81:50] !== want.cur_order_size_limit) begin
               report_mismatch("cur_order_size_limit", 64'(rsp_tdata[81:50]),
                               64'(want.cur_order_size_limit));
            end
            if (rsp_tdata[128:82] !== want.cur_position_limit) begin
               report_mismatch("cur_position_limit", 64'(rsp_tdata[128:82]),
                               64'(want.cur_position_limit));
            end
            if (rsp_tdata[160:129] !== want.cur_rate_limit) begin
               report_mismatch("cur_rate_limit", 64'(rsp_tdata[160:129]),
                               64'(want.cur_rate_limit));
            end
         end
      end
   end

   // Ends the run when no request, result or register write moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ptrg_pkg::OP_QUERY;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_absent_entries();
      test_order_checks();
      test_window_extremes();
      test_large_fills();
      test_random_traffic();

      // Let the pipeline settle after the last result.
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
